[rtl/core/tzjd_pkg.sv]
// Shared types, constants and widths for the trajectory zigzag/jump detector.
// No dependencies.
package tzjd_pkg;
  localparam int unsigned CoordWidthDef = 32;
  localparam logic [15:0] RatioReset = 16'd6554;
  localparam logic [7:0]  FactorReset = 8'd10;
  localparam logic [1:0]  CfgIdxRatio = 2'd0;
  localparam logic [1:0]  CfgIdxFactor = 2'd1;
  localparam logic [1:0]  ReasonNone = 2'd0;
  localparam logic [1:0]  ReasonZig = 2'd1;
  localparam logic [1:0]  ReasonJump = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // take input item
    logic seg_start; // start a segment length
    logic [2:0] seg_sel;
    logic sq_step;   // one multiply or one root bit
    logic decide;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic [1:0] count;
    logic seg_done;
  } dp_sts_t;
endpackage

[rtl/core/trajectory_zigzag_jump_detector_top.sv]
// Trajectory zigzag/jump detector top level; uses tzjd_pkg, tzjd_ctrl, tzjd_datapath.
// A start item or an advect with under two points computes no segment length; the second
// advect computes two segment lengths and later advects five, one after another on the one
// shared bit-serial root unit.
// Throughput: one item at a time; the next is taken the cycle after the result leaves.
// Reset (rst_ni low, asynchronous) clears the path, latch and registers to defaults.
module trajectory_zigzag_jump_detector_top import tzjd_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  logic action_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic captured_o,
  output logic [1:0] reason_o,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic [15:0] ratio_q;
  logic [7:0] factor_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioReset; factor_q <= FactorReset;
    end else if (cfg_valid) begin
      if (cfg_index_i == CfgIdxRatio) ratio_q <= cfg_data_i;
      else if (cfg_index_i == CfgIdxFactor) factor_q <= cfg_data_i[7:0];
    end
  end

  tzjd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd)
  );

  tzjd_datapath #(.CoordWidth(CoordWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .action_i, .value_x_i, .value_y_i,
    .value_z_i, .ratio_i(ratio_q), .factor_i(factor_q), .pos_x_o, .pos_y_o,
    .pos_z_o, .captured_o, .reason_o
  );
endmodule

[rtl/core/tzjd_datapath.sv]
// Datapath: position and history registers, one shared segment-length unit
// (squares then bit-serial root), decision logic and output register. Uses tzjd_pkg.
module tzjd_datapath import tzjd_pkg::*; #(
  parameter int unsigned CoordWidth = CoordWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  input  logic action_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  input  logic [15:0] ratio_i,
  input  logic [7:0] factor_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic captured_o,
  output logic [1:0] reason_o
);
  localparam int unsigned CW = CoordWidth;
  localparam int unsigned DW = CW + 1;       // magnitude of a difference
  localparam int unsigned SW = 2 * DW + 2;   // sum of three squares
  localparam int unsigned RW = CW + 2;       // root bits
  localparam int unsigned BW = $clog2(RW + 1);

  logic [CW-1:0] px_q[4], py_q[4], pz_q[4];
  logic [1:0] cnt_q;
  logic act_q, latch_q;
  logic [31:0] vx_q, vy_q, vz_q;
  logic [RW-1:0] seg_q[5];
  logic [DW-1:0] d_q[3];
  logic [SW-1:0] acc_q, rem_q;
  logic [RW-1:0] root_q;
  logic [BW-1:0] bit_q;
  logic [1:0] ph_q;
  logic [2:0] sel_q;
  logic done;

  function automatic logic [DW-1:0] absd(logic [CW-1:0] a, logic [CW-1:0] b);
    logic signed [DW-1:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  logic [CW-1:0] ax, ay, az, bx, by, bz;
  always_comb begin
    ax = px_q[0]; ay = py_q[0]; az = pz_q[0];
    bx = px_q[1]; by = py_q[1]; bz = pz_q[1];
    case (cmd_i.seg_sel)
      3'd1: begin
        ax = px_q[1]; ay = py_q[1]; az = pz_q[1];
        bx = px_q[2]; by = py_q[2]; bz = pz_q[2];
      end
      3'd2: begin
        ax = px_q[2]; ay = py_q[2]; az = pz_q[2];
        bx = px_q[3]; by = py_q[3]; bz = pz_q[3];
      end
      3'd3: begin
        bx = px_q[2]; by = py_q[2]; bz = pz_q[2];
      end
      3'd4: begin
        ax = px_q[1]; ay = py_q[1]; az = pz_q[1];
        bx = px_q[3]; by = py_q[3]; bz = pz_q[3];
      end
      default: ;
    endcase
  end

  logic [SW-1:0] sq;
  logic [RW-1:0] trial;
  logic [SW-1:0] tsq;
  always_comb begin
    sq = SW'(d_q[ph_q]) * SW'(d_q[ph_q]);
    trial = root_q | (RW'(1) << bit_q);
    tsq = SW'(trial) * SW'(trial);
  end
  assign done = (ph_q == 2'd3) && (bit_q == '0);

  // sign-extend or truncate inputs to the coordinate width
  logic [CW-1:0] ix, iy, iz;
  assign ix = CW'($signed(vx_q));
  assign iy = CW'($signed(vy_q));
  assign iz = CW'($signed(vz_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; latch_q <= 1'b0; ph_q <= 2'd3; bit_q <= '0;
      act_q <= 1'b0; vx_q <= '0; vy_q <= '0; vz_q <= '0;
      acc_q <= '0; root_q <= '0; sel_q <= '0;
      reason_o <= ReasonNone; captured_o <= 1'b0;
      pos_x_o <= '0; pos_y_o <= '0; pos_z_o <= '0;
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= '0; py_q[i] <= '0; pz_q[i] <= '0;
      end
      for (int i = 0; i < 5; i++) seg_q[i] <= '0;
      for (int i = 0; i < 3; i++) d_q[i] <= '0;
    end else begin
      if (cmd_i.load) begin
        act_q <= action_i; vx_q <= value_x_i; vy_q <= value_y_i; vz_q <= value_z_i;
      end
      if (cmd_i.seg_start && cmd_i.seg_sel == 3'd7) begin
        // apply the step
        if (!act_q) begin
          px_q[0] <= ix; py_q[0] <= iy; pz_q[0] <= iz;
          for (int i = 1; i < 4; i++) begin
            px_q[i] <= '0; py_q[i] <= '0; pz_q[i] <= '0;
          end
          cnt_q <= '0; latch_q <= 1'b0;
        end else begin
          for (int i = 1; i < 4; i++) begin
            px_q[i] <= px_q[i-1]; py_q[i] <= py_q[i-1]; pz_q[i] <= pz_q[i-1];
          end
          px_q[0] <= px_q[0] + ix; py_q[0] <= py_q[0] + iy; pz_q[0] <= pz_q[0] + iz;
          if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
        end
      end else if (cmd_i.seg_start) begin
        d_q[0] <= absd(ax, bx); d_q[1] <= absd(ay, by); d_q[2] <= absd(az, bz);
        acc_q <= '0; root_q <= '0; ph_q <= 2'd0; sel_q <= cmd_i.seg_sel;
        bit_q <= BW'(RW - 1);
      end else if (cmd_i.sq_step && !done) begin
        if (ph_q != 2'd3) begin
          acc_q <= acc_q + sq;
          ph_q <= ph_q + 2'd1;
        end else begin
          if (tsq <= acc_q) root_q <= trial;
          bit_q <= bit_q - BW'(1);
        end
      end
      if (cmd_i.sq_step && done) begin
        seg_q[sel_q] <= (tsq <= acc_q) ? trial : root_q;
        ph_q <= 2'd3; bit_q <= '0;
      end
      if (cmd_i.decide) begin
        logic [1:0] rs;
        rs = ReasonNone;
        if (act_q && cnt_q >= 2'd2) begin
          logic jmp, t1, t2;
          logic [RW:0] p1, p2;
          p1 = {1'b0, seg_q[0]} + {1'b0, seg_q[1]};
          p2 = {1'b0, seg_q[1]} + {1'b0, seg_q[2]};
          jmp = {8'd0, seg_q[0]} > ((RW+8)'(factor_i) * (RW+8)'(seg_q[1]));
          t1 = (p1 != '0) &&
               ({1'b0, seg_q[3], 16'd0} <= ((RW+17)'(ratio_i) * (RW+17)'(p1)));
          t2 = (p2 != '0) &&
               ({1'b0, seg_q[4], 16'd0} <= ((RW+17)'(ratio_i) * (RW+17)'(p2)));
          if (cnt_q == 2'd3 && t1 && t2) rs = ReasonZig;
          else if (jmp) rs = ReasonJump;
        end
        reason_o <= rs;
        if (rs != ReasonNone) latch_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        pos_x_o <= 32'($signed(px_q[0]));
        pos_y_o <= 32'($signed(py_q[0]));
        pos_z_o <= 32'($signed(pz_q[0]));
        captured_o <= latch_q;
      end
    end
  end

  assign sts_o.is_start = act_q == 1'b0;
  assign sts_o.count = cnt_q;
  assign sts_o.seg_done = done;
endmodule

[rtl/core/tzjd_ctrl.sv]
// Controller: sequences load, step update, up to five segment lengths, decision and
// output handshake. Uses tzjd_pkg.
module tzjd_ctrl import tzjd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  localparam logic [2:0] SIdle = 3'd0, SUpd = 3'd1, SSegSt = 3'd2, SSeg = 3'd3,
                         SDec = 3'd4, SOut = 3'd5;
  logic [2:0] st_q, st_d;
  logic [2:0] seg_q, seg_d;
  logic ov_q, ov_d;

  always_comb begin
    st_d = st_q; seg_d = seg_q; ov_d = ov_q;
    cmd_o = '0;
    in_stall = (st_q != SIdle) || ov_q;
    if (ov_q && !out_stall) ov_d = 1'b0;
    unique case (st_q)
      SIdle: if (in_valid && !in_stall) begin
        cmd_o.load = 1'b1; st_d = SUpd;
      end
      SUpd: begin
        cmd_o.seg_start = 1'b1; cmd_o.seg_sel = 3'd7; seg_d = 3'd0;
        st_d = SSegSt;
      end
      SSegSt: begin
        if (sts_i.is_start || sts_i.count < 2'd2 ||
            (sts_i.count == 2'd2 && seg_q >= 3'd2) || seg_q == 3'd5) st_d = SDec;
        else begin
          cmd_o.seg_start = 1'b1; cmd_o.seg_sel = seg_q; st_d = SSeg;
        end
      end
      SSeg: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.seg_done) begin
          seg_d = seg_q + 3'd1; st_d = SSegSt;
        end
      end
      SDec: begin
        cmd_o.decide = 1'b1; st_d = SOut;
      end
      SOut: if (!ov_q) begin
        cmd_o.out_load = 1'b1; ov_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end
  assign out_valid = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; seg_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; seg_q <= seg_d; ov_q <= ov_d;
    end
  end
endmodule

[rtl/core/tzjd_checker.sv]
// Port-level checks for the detector top level; bound to it below.
// Depends on tzjd_pkg.
module tzjd_checker import tzjd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic captured_o,
  input logic [1:0] reason_o
);
  a_one_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> reason_o != 2'd3) else $error("bad reason code");
  a_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && reason_o != ReasonNone) |-> captured_o)
    else $error("detection not latched");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

bind trajectory_zigzag_jump_detector_top tzjd_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .captured_o, .reason_o
);
